### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPL(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

### rtl/swarq_pkg.sv
package swarq_pkg;

    // Default limits handed to the top-level parameters.
    localparam int DEF_MAX_WINDOW  = 16;
    localparam int DEF_MAX_PACKETS = 256;
    localparam int DEF_MAX_CHUNK   = 8;

    // Configuration register widths and port shape.
    localparam int MLEN_W     = 12;
    localparam int CHUNK_W    = 4;
    localparam int PCNT_W     = 9;
    localparam int WIN_W      = 5;
    localparam int TRIES_W    = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 12;

    // Register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_MESSAGE_LENGTH = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CHUNK_SIZE     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PACKET_COUNT   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_SIZE    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_TRIES      = 3'd4;

    // Register values after reset.
    localparam logic [MLEN_W-1:0]  RST_MESSAGE_LENGTH = 12'd40;
    localparam logic [CHUNK_W-1:0] RST_CHUNK_SIZE     = 4'd8;
    localparam logic [PCNT_W-1:0]  RST_PACKET_COUNT   = 9'd5;
    localparam logic [WIN_W-1:0]   RST_WINDOW_SIZE    = 5'd4;
    localparam logic [TRIES_W-1:0] RST_MAX_TRIES      = 8'd10;

    // Input and result field widths.
    localparam int OP_W   = 2;
    localparam int BYTE_W = 8;
    localparam int SEQ_W  = 8;
    localparam int OFF_W  = 11;
    localparam int LEN_W  = 4;
    localparam int KIND_W = 2;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 24;

    // Internal datapath widths: packet index within a burst, running offset, remainder.
    localparam int IDX_W    = 9;
    localparam int OFFACC_W = IDX_W + CHUNK_W;
    localparam int REM_W    = OFFACC_W + 1;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_START   = 2'd0;
    localparam logic [OP_W-1:0] OP_ACK     = 2'd1;
    localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd2;

    localparam logic [BYTE_W-1:0] ACK_TYPE = 8'd2;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_SEND     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TEARDOWN = 2'd1;
    localparam logic [KIND_W-1:0] KIND_GIVEUP   = 2'd2;

    // Micro-operations.
    localparam int UOP_W  = 4;
    localparam int STEP_W = 4;
    localparam logic [UOP_W-1:0] U_FETCH      = 4'd0;
    localparam logic [UOP_W-1:0] U_TEST_START = 4'd1;
    localparam logic [UOP_W-1:0] U_TEST_ACK   = 4'd2;
    localparam logic [UOP_W-1:0] U_TEST_TMO   = 4'd3;
    localparam logic [UOP_W-1:0] U_START      = 4'd4;
    localparam logic [UOP_W-1:0] U_ACK        = 4'd5;
    localparam logic [UOP_W-1:0] U_ACK_END    = 4'd6;
    localparam logic [UOP_W-1:0] U_ACK_SENT   = 4'd7;
    localparam logic [UOP_W-1:0] U_TMO_INC    = 4'd8;
    localparam logic [UOP_W-1:0] U_TMO_CHK    = 4'd9;
    localparam logic [UOP_W-1:0] U_BSETUP     = 4'd10;
    localparam logic [UOP_W-1:0] U_BEMIT      = 4'd11;
    localparam logic [UOP_W-1:0] U_TEARDOWN   = 4'd12;
    localparam logic [UOP_W-1:0] U_GIVEUP     = 4'd13;

    // Program addresses.
    localparam logic [STEP_W-1:0] S_FETCH      = 4'd0;
    localparam logic [STEP_W-1:0] S_TEST_START = 4'd1;
    localparam logic [STEP_W-1:0] S_TEST_ACK   = 4'd2;
    localparam logic [STEP_W-1:0] S_TEST_TMO   = 4'd3;
    localparam logic [STEP_W-1:0] S_START      = 4'd4;
    localparam logic [STEP_W-1:0] S_ACK        = 4'd5;
    localparam logic [STEP_W-1:0] S_ACK_END    = 4'd6;
    localparam logic [STEP_W-1:0] S_ACK_SENT   = 4'd7;
    localparam logic [STEP_W-1:0] S_TMO_INC    = 4'd8;
    localparam logic [STEP_W-1:0] S_TMO_CHK    = 4'd9;
    localparam logic [STEP_W-1:0] S_BSETUP     = 4'd10;
    localparam logic [STEP_W-1:0] S_BEMIT      = 4'd11;
    localparam logic [STEP_W-1:0] S_TEARDOWN   = 4'd12;
    localparam logic [STEP_W-1:0] S_GIVEUP     = 4'd13;

    // One control word: the operation, the fall-through step and the taken step.
    typedef struct packed {
        logic [UOP_W-1:0]  uop;
        logic [STEP_W-1:0] next_step;
        logic [STEP_W-1:0] jump_step;
    } ucode_t;

    // Control store. A word moves to jump_step when its condition holds.
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        case (step)
            S_FETCH:      w = '{U_FETCH,      S_TEST_START, S_TEST_START};
            S_TEST_START: w = '{U_TEST_START, S_TEST_ACK,   S_START};
            S_TEST_ACK:   w = '{U_TEST_ACK,   S_TEST_TMO,   S_ACK};
            S_TEST_TMO:   w = '{U_TEST_TMO,   S_FETCH,      S_TMO_INC};
            S_START:      w = '{U_START,      S_BSETUP,     S_BSETUP};
            S_ACK:        w = '{U_ACK,        S_ACK_END,    S_FETCH};
            S_ACK_END:    w = '{U_ACK_END,    S_ACK_SENT,   S_TEARDOWN};
            S_ACK_SENT:   w = '{U_ACK_SENT,   S_FETCH,      S_BSETUP};
            S_TMO_INC:    w = '{U_TMO_INC,    S_TMO_CHK,    S_TMO_CHK};
            S_TMO_CHK:    w = '{U_TMO_CHK,    S_BSETUP,     S_GIVEUP};
            S_BSETUP:     w = '{U_BSETUP,     S_BEMIT,      S_BEMIT};
            S_BEMIT:      w = '{U_BEMIT,      S_FETCH,      S_BEMIT};
            S_TEARDOWN:   w = '{U_TEARDOWN,   S_FETCH,      S_FETCH};
            S_GIVEUP:     w = '{U_GIVEUP,     S_FETCH,      S_FETCH};
            default:      w = '{U_FETCH,      S_FETCH,      S_FETCH};
        endcase
        return w;
    endfunction

endpackage

### rtl/sliding_window_arq_sender_core.sv
// Steps: a start transfer passes the start test, the start step and burst setup into the emit
// loop; a timeout passes the three tests and the retry increment and check before burst setup;
// an acknowledgement that opens a new window passes two tests and the ack steps before it.
// Throughput: one microprogram step per cycle unless fetch, emit, teardown or give-up stalls; a
// burst gives one result per cycle while m_tready holds. Items are taken only in fetch.
// Reset (rst_n low, asynchronous) restores the register defaults and leaves the sender idle.
module sliding_window_arq_sender_core #(
    parameter int MAX_WINDOW  = swarq_pkg::DEF_MAX_WINDOW,
    parameter int MAX_PACKETS = swarq_pkg::DEF_MAX_PACKETS,
    parameter int MAX_CHUNK   = swarq_pkg::DEF_MAX_CHUNK
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write port.
    input  logic                              cfg_we,
    input  logic [swarq_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [swarq_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // Input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [swarq_pkg::S_DATA_W-1:0]    s_tdata,   // ack_type[7:0], ack_number[15:8]
    input  logic [swarq_pkg::OP_W-1:0]        s_tuser,   // operation[1:0]
    // Result stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [swarq_pkg::M_DATA_W-1:0]    m_tdata,   // seq_no[7:0], byte_offset[18:8],
                                                         // length[22:19], zero[23]
    output logic [swarq_pkg::KIND_W-1:0]      m_tuser,   // kind[1:0]
    output logic                              m_tlast
);
    import swarq_pkg::*;

    // Caps for out-of-range register values, limited to what each register can hold.
    localparam int CH_LIM  = (MAX_CHUNK < (1 << CHUNK_W)) ? MAX_CHUNK : (1 << CHUNK_W) - 1;
    localparam int PC_LIM  = (MAX_PACKETS < (1 << PCNT_W)) ? MAX_PACKETS : (1 << PCNT_W) - 1;
    localparam int WIN_LIM = (MAX_WINDOW < (1 << WIN_W)) ? MAX_WINDOW : (1 << WIN_W) - 1;
    localparam logic [CHUNK_W-1:0] CH_CAP  = CHUNK_W'(CH_LIM);
    localparam logic [PCNT_W-1:0]  PC_CAP  = PCNT_W'(PC_LIM);
    localparam logic [WIN_W-1:0]   WIN_CAP = WIN_W'(WIN_LIM);

    // Configuration registers.
    logic [MLEN_W-1:0]  mlen_reg;
    logic [CHUNK_W-1:0] chunk_reg;
    logic [PCNT_W-1:0]  pcnt_reg;
    logic [WIN_W-1:0]   win_reg;
    logic [TRIES_W-1:0] tries_reg;

    // Protocol state. acked and sent count packets, one above the acknowledged and
    // highest-sent packet indexes.
    logic [PCNT_W-1:0]  acked_reg, acked_next;
    logic [PCNT_W-1:0]  sent_reg, sent_next;
    logic [SEQ_W-1:0]   base_reg, base_next;
    logic [TRIES_W-1:0] retry_reg, retry_next;
    logic               running_reg, running_next;

    // Sequencer and latched input item.
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [OP_W-1:0]    op_reg;
    logic [BYTE_W-1:0]  atype_reg;
    logic [BYTE_W-1:0]  anum_reg;

    // Burst datapath.
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [WIN_W-1:0]    cnt_reg, cnt_next;
    logic [OFFACC_W-1:0] off_reg, off_next;

    // Output register.
    logic               out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]  out_kind_reg, out_kind_next;
    logic [SEQ_W-1:0]   out_seq_reg, out_seq_next;
    logic [OFF_W-1:0]   out_off_reg, out_off_next;
    logic [LEN_W-1:0]   out_len_reg, out_len_next;
    logic               out_last_reg, out_last_next;
    logic               out_load;

    // Control word and decoded conditions.
    ucode_t             uw;
    logic               cond;
    logic               stall;
    logic               in_xfer;
    logic               out_space;

    // Effective register values.
    logic [CHUNK_W-1:0] ch_eff;
    logic [PCNT_W-1:0]  pc_eff;
    logic [WIN_W-1:0]   win_eff;

    // Burst arithmetic.
    logic [SEQ_W+CHUNK_W-1:0] base_prod;
    logic [REM_W-1:0]   rem;
    logic               rem_neg;
    logic               rem_ge_ch;
    logic [LEN_W-1:0]   len_val;
    logic [IDX_W:0]     idx_inc;
    logic [IDX_W:0]     sent_max;
    logic               emit_ok;
    logic               burst_done;

    // Zero and over-range register values fold onto the legal range.
    always_comb
    begin
        ch_eff  = (chunk_reg == '0) ? CHUNK_W'(1) : ((chunk_reg > CH_CAP) ? CH_CAP : chunk_reg);
        pc_eff  = (pcnt_reg == '0) ? PCNT_W'(1) : ((pcnt_reg > PC_CAP) ? PC_CAP : pcnt_reg);
        win_eff = (win_reg == '0) ? WIN_W'(1) : ((win_reg > WIN_CAP) ? WIN_CAP : win_reg);
    end

    assign uw        = ucode_rom(step_reg);
    assign s_tready  = (uw.uop == U_FETCH);
    assign in_xfer   = s_tvalid && s_tready;
    assign out_space = !out_valid_reg || m_tready;

    // Packet arithmetic for the current burst slot.
    assign base_prod = base_reg * ch_eff;
    assign rem       = {{(REM_W-MLEN_W){1'b0}}, mlen_reg} - {1'b0, off_reg};
    assign rem_neg   = rem[REM_W-1];
    assign rem_ge_ch = !rem_neg && (rem >= {{(REM_W-CHUNK_W){1'b0}}, ch_eff});
    assign idx_inc   = {1'b0, idx_reg} + {{IDX_W{1'b0}}, 1'b1};
    assign sent_max  = (idx_inc > {1'b0, sent_reg}) ? idx_inc : {1'b0, sent_reg};
    assign emit_ok   = (idx_reg < pc_eff);
    assign burst_done = !emit_ok || (cnt_reg == (win_eff - WIN_W'(1)))
                        || (idx_inc >= {1'b0, pc_eff});

    // Remaining bytes of the message, clipped to one chunk.
    always_comb
    begin
        if (rem_ge_ch)
        begin
            len_val = ch_eff;
        end
        else if (rem_neg)
        begin
            len_val = '0;
        end
        else
        begin
            len_val = rem[LEN_W-1:0];
        end
    end

    // Datapath actions of each micro-operation.
    always_comb
    begin
        acked_next     = acked_reg;
        sent_next      = sent_reg;
        base_next      = base_reg;
        retry_next     = retry_reg;
        running_next   = running_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        off_next       = off_reg;
        out_load       = 1'b0;
        out_kind_next  = out_kind_reg;
        out_seq_next   = out_seq_reg;
        out_off_next   = out_off_reg;
        out_len_next   = out_len_reg;
        out_last_next  = out_last_reg;
        cond           = 1'b0;
        stall          = 1'b0;
        case (uw.uop)
            U_FETCH:
            begin
                stall = !s_tvalid;
            end
            U_TEST_START:
            begin
                cond = (op_reg == OP_START);
            end
            U_TEST_ACK:
            begin
                cond = (op_reg == OP_ACK) && running_reg;
            end
            U_TEST_TMO:
            begin
                cond = (op_reg == OP_TIMEOUT) && running_reg;
            end
            U_START:
            begin
                acked_next   = '0;
                sent_next    = '0;
                base_next    = '0;
                retry_next   = '0;
                running_next = 1'b1;
            end
            U_ACK:
            begin
                // Wrong type or a stale number leaves everything as it is.
                cond = (atype_reg != ACK_TYPE) || ({1'b0, anum_reg} < acked_reg);
                if (!cond)
                begin
                    acked_next = acked_reg + PCNT_W'(1);
                    retry_next = '0;
                end
            end
            U_ACK_END:
            begin
                cond = (acked_reg >= pc_eff);
                if (!cond)
                begin
                    base_next = acked_reg[SEQ_W-1:0];
                end
            end
            U_ACK_SENT:
            begin
                cond = (acked_reg == sent_reg);
            end
            U_TMO_INC:
            begin
                if (retry_reg != '1)
                begin
                    retry_next = retry_reg + TRIES_W'(1);
                end
            end
            U_TMO_CHK:
            begin
                cond = (retry_reg >= tries_reg);
            end
            U_BSETUP:
            begin
                idx_next = {{(IDX_W-SEQ_W){1'b0}}, base_reg};
                cnt_next = '0;
                off_next = {{(OFFACC_W-SEQ_W-CHUNK_W){1'b0}}, base_prod};
            end
            U_BEMIT:
            begin
                // One window slot per cycle unless stalled; one past the last packet ends it.
                stall = emit_ok && !out_space;
                cond  = !burst_done;
                if (!stall)
                begin
                    out_load      = emit_ok;
                    out_kind_next = KIND_SEND;
                    out_seq_next  = idx_reg[SEQ_W-1:0];
                    out_off_next  = off_reg[OFF_W-1:0];
                    out_len_next  = len_val;
                    out_last_next = burst_done;
                    sent_next     = (sent_max > {1'b0, pc_eff}) ? pc_eff : sent_max[PCNT_W-1:0];
                    idx_next      = idx_inc[IDX_W-1:0];
                    cnt_next      = cnt_reg + WIN_W'(1);
                    off_next      = off_reg + {{(OFFACC_W-CHUNK_W){1'b0}}, ch_eff};
                end
            end
            U_TEARDOWN, U_GIVEUP:
            begin
                stall = !out_space;
                if (!stall)
                begin
                    out_load      = 1'b1;
                    out_kind_next = (uw.uop == U_TEARDOWN) ? KIND_TEARDOWN : KIND_GIVEUP;
                    out_seq_next  = '0;
                    out_off_next  = '0;
                    out_len_next  = '0;
                    out_last_next = 1'b1;
                    running_next  = 1'b0;
                end
            end
            default:
            begin
                stall = 1'b0;
            end
        endcase
    end

    // Step sequencing: hold on a stall, else take the jump or fall through.
    always_comb
    begin
        if (stall)
        begin
            step_next = step_reg;
        end
        else if (cond)
        begin
            step_next = uw.jump_step;
        end
        else
        begin
            step_next = uw.next_step;
        end
    end

    assign out_valid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    // Configuration registers take writes at any edge with the enable high.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mlen_reg  <= RST_MESSAGE_LENGTH;
            chunk_reg <= RST_CHUNK_SIZE;
            pcnt_reg  <= RST_PACKET_COUNT;
            win_reg   <= RST_WINDOW_SIZE;
            tries_reg <= RST_MAX_TRIES;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_MESSAGE_LENGTH: mlen_reg  <= cfg_wdata[MLEN_W-1:0];
                REG_CHUNK_SIZE:     chunk_reg <= cfg_wdata[CHUNK_W-1:0];
                REG_PACKET_COUNT:   pcnt_reg  <= cfg_wdata[PCNT_W-1:0];
                REG_WINDOW_SIZE:    win_reg   <= cfg_wdata[WIN_W-1:0];
                REG_MAX_TRIES:      tries_reg <= cfg_wdata[TRIES_W-1:0];
                default:            mlen_reg  <= mlen_reg;
            endcase
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= S_FETCH;
            acked_reg     <= '0;
            sent_reg      <= '0;
            base_reg      <= '0;
            retry_reg     <= '0;
            running_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            acked_reg     <= acked_next;
            sent_reg      <= sent_next;
            base_reg      <= base_next;
            retry_reg     <= retry_next;
            running_reg   <= running_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: input latch, burst counters and the result word.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg    <= s_tuser;
            atype_reg <= s_tdata[BYTE_W-1:0];
            anum_reg  <= s_tdata[2*BYTE_W-1:BYTE_W];
        end
        idx_reg <= idx_next;
        cnt_reg <= cnt_next;
        off_reg <= off_next;
        if (out_load)
        begin
            out_kind_reg <= out_kind_next;
            out_seq_reg  <= out_seq_next;
            out_off_reg  <= out_off_next;
            out_len_reg  <= out_len_next;
            out_last_reg <= out_last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(M_DATA_W-SEQ_W-OFF_W-LEN_W){1'b0}}, out_len_reg, out_off_reg,
                       out_seq_reg};

endmodule

### rtl/swarq_checker.sv
`include "assert_macros.svh"

module swarq_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [swarq_pkg::M_DATA_W-1:0] m_tdata,
    input  logic [swarq_pkg::KIND_W-1:0]   m_tuser,
    input  logic                           m_tlast
);
    import swarq_pkg::*;

    logic                             kind_ok;
    logic                             ctrl_result;
    logic [M_DATA_W+KIND_W:0]         m_word;

    // Result decoding used by the checks below.
    assign kind_ok     = (m_tuser == KIND_SEND) || (m_tuser == KIND_TEARDOWN)
                         || (m_tuser == KIND_GIVEUP);
    assign ctrl_result = m_tvalid && (m_tuser != KIND_SEND);
    assign m_word      = {m_tlast, m_tuser, m_tdata};

    // A result that is not taken stays offered.
    `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

    // Only the three defined kinds are ever offered.
    `ASSERT_IMPL(a_kind_legal, m_tvalid, kind_ok, "undefined result kind")

    // Teardown and give-up are single results with an empty payload.
    `ASSERT_IMPL(a_single_empty, ctrl_result, m_tlast && m_tdata == '0, "final result not empty")

    // No new item is taken while a burst still owes results.
    `ASSERT_IMPL(a_no_accept_mid_burst, m_tvalid && !m_tlast, !s_tready, "input taken mid-burst")

    // A stalled result keeps its payload until it is taken.
    `ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_word), "result changed in stall")

endmodule

bind sliding_window_arq_sender_core swarq_checker u_swarq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
